// ----- rtl/rph_pkg.sv -----
`default_nettype none

package rph_pkg;

    // Largest number of bytes the string store holds.
    localparam int unsigned MAX_LEN = 1024;

    localparam int unsigned HASH_W = 61;
    localparam int unsigned BASE_W = 31;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned ACT_W  = 2;

    localparam logic [HASH_W-1:0] MERSENNE_P = '1;
    localparam logic [BASE_W-1:0] RESET_BASE = BASE_W'(258);

    // Register index decoded from paddr[2].
    localparam logic REG_HASH_BASE = 1'b0;

    // Item actions.
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd3;

    // Prefix memory read address selects.
    localparam logic [1:0] PSEL_LEN = 2'd0;
    localparam logic [1:0] PSEL_POS = 2'd1;
    localparam logic [1:0] PSEL_END = 2'd2;

    // Power memory read address selects.
    localparam logic WSEL_LEN  = 1'b0;
    localparam logic WSEL_SPAN = 1'b1;

    // Multiplier operand selects.
    localparam logic OPA_PREFIX = 1'b0;
    localparam logic OPA_POWER  = 1'b1;
    localparam logic OPB_BASE   = 1'b0;
    localparam logic OPB_POWER  = 1'b1;

    // Result hash selects.
    localparam logic [1:0] HV_ZERO   = 2'd0;
    localparam logic [1:0] HV_PREFIX = 2'd1;
    localparam logic [1:0] HV_ADD    = 2'd2;
    localparam logic [1:0] HV_SUB    = 2'd3;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        logic       load_item;
        logic       rd_prefix;
        logic [1:0] prefix_sel;
        logic       rd_power;
        logic       power_sel;
        logic       mul_start;
        logic       opa_sel;
        logic       opb_sel;
        logic       hv_load;
        logic [1:0] hv_sel;
        logic       err_val;
        logic       len_clear;
        logic       append_commit;
        logic       out_load;
    } rph_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             range_err;
        logic             mul_done;
    } rph_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rph_mulmod.sv -----
`default_nettype none

// Product of two residues modulo 2^61-1 on one shared 32x32 multiplier.
// Four partial products, then sum, fold and final correction; done pulses
// for one cycle with the result.
module rph_mulmod (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire rph_pkg::hash_t  op_a,
    input  wire rph_pkg::hash_t  op_b,
    output logic                 done,
    output rph_pkg::hash_t       result
);
    import rph_pkg::*;

    logic        busy_reg;
    logic [2:0]  step_reg;
    logic        done_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] pp;
    logic [63:0] pp_reg;
    logic [63:0] lo_reg;
    logic [64:0] mid_reg;
    logic [57:0] hi_reg;
    logic [63:0] sum;
    logic [63:0] sum_reg;
    logic [61:0] fold1;
    logic [61:0] fold2;
    logic [61:0] fold_reg;
    logic [61:0] fixed;
    hash_t       result_reg;

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                op_x = op_a[31:0];
                op_y = op_b[31:0];
            end
            2'd1:
            begin
                op_x = op_a[31:0];
                op_y = {3'b000, op_b[60:32]};
            end
            2'd2:
            begin
                op_x = {3'b000, op_a[60:32]};
                op_y = op_b[31:0];
            end
            default:
            begin
                op_x = {3'b000, op_a[60:32]};
                op_y = {3'b000, op_b[60:32]};
            end
        endcase
    end

    assign pp = op_x * op_y;

    // 2^61 is 1 modulo the prime, so higher weights fold back by rotation.
    assign sum = {3'b000, lo_reg[60:0]} + {61'd0, lo_reg[63:61]}
               + {3'b000, hi_reg, 3'b000} + {28'd0, mid_reg[64:29]}
               + {3'b000, mid_reg[28:0], 32'd0};
    assign fold1 = {1'b0, sum_reg[60:0]} + {59'd0, sum_reg[63:61]};
    assign fold2 = {1'b0, fold1[60:0]} + {61'd0, fold1[61]};
    assign fixed = (fold_reg >= {1'b0, MERSENNE_P}) ? (fold_reg - {1'b0, MERSENNE_P})
                                                   : fold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 3'd7);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (!step_reg[2])
            begin
                pp_reg <= pp;
            end
            unique case (step_reg)
                3'd1: lo_reg <= pp_reg;
                3'd2: mid_reg <= {1'b0, pp_reg};
                3'd3: mid_reg <= mid_reg + {1'b0, pp_reg};
                3'd4: hi_reg <= pp_reg[57:0];
                3'd5: sum_reg <= sum;
                3'd6: fold_reg <= fold2;
                3'd7: result_reg <= fixed[60:0];
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg != MERSENNE_P))
        else $error("multiplier result not fully reduced");
`endif

endmodule

`default_nettype wire

// ----- rtl/rph_datapath.sv -----
`default_nettype none

// Item registers, prefix and power memories, length count, the shared
// modular multiplier and the output register.
module rph_datapath (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire rph_pkg::rph_cmd_t             cmd,
    output rph_pkg::rph_stat_t                 stat,
    input  wire [rph_pkg::BASE_W-1:0]          hash_base,
    input  wire [rph_pkg::ACT_W-1:0]           in_action,
    input  wire [rph_pkg::SYM_W-1:0]           in_symbol,
    input  wire rph_pkg::len_t                 in_start_pos,
    input  wire rph_pkg::len_t                 in_span_len,
    output rph_pkg::hash_t                     hash_value,
    output logic                               status,
    output rph_pkg::len_t                      stored_length
);
    import rph_pkg::*;

    logic [ACT_W-1:0] act_reg;
    logic [SYM_W-1:0] sym_reg;
    len_t             pos_reg;
    len_t             span_reg;
    len_t             length_count_reg;
    logic [LEN_W:0]   end_sum;
    len_t             prefix_addr;
    len_t             power_addr;
    len_t             wr_addr;

    hash_t            prefix_mem [0:MAX_LEN];
    hash_t            power_mem  [0:MAX_LEN];
    hash_t            prefix_raw_reg;
    hash_t            power_raw_reg;
    logic             prefix_zero_reg;
    logic             power_zero_reg;
    hash_t            prefix_q;
    hash_t            power_q;

    hash_t            op_a_reg;
    hash_t            op_b_reg;
    logic             mul_done;
    hash_t            mul_result;

    hash_t            hv_reg;
    hash_t            hv_next;
    logic             err_reg;
    hash_t            hv_out_reg;
    logic             err_out_reg;
    len_t             len_out_reg;

    logic [HASH_W:0]  add_wide;
    logic [HASH_W:0]  sub_wide;

    assign end_sum = {1'b0, pos_reg} + {1'b0, span_reg};
    assign wr_addr = length_count_reg + len_t'(1);

    always_comb
    begin
        unique case (cmd.prefix_sel)
            PSEL_POS: prefix_addr = pos_reg;
            PSEL_END: prefix_addr = end_sum[LEN_W-1:0];
            default:  prefix_addr = length_count_reg;
        endcase
        power_addr = (cmd.power_sel == WSEL_SPAN) ? span_reg : length_count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg  <= in_action;
            sym_reg  <= in_symbol;
            pos_reg  <= in_start_pos;
            span_reg <= in_span_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_count_reg <= '0;
        end
        else if (cmd.len_clear)
        begin
            length_count_reg <= '0;
        end
        else if (cmd.append_commit)
        begin
            length_count_reg <= wr_addr;
        end
    end

    // Entry zero is never written; its fixed value replaces the memory word.
    always_ff @(posedge clk)
    begin
        if (cmd.append_commit)
        begin
            prefix_mem[wr_addr] <= hv_reg;
        end
        if (cmd.rd_prefix)
        begin
            prefix_raw_reg  <= prefix_mem[prefix_addr];
            prefix_zero_reg <= (prefix_addr == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append_commit)
        begin
            power_mem[wr_addr] <= mul_result;
        end
        if (cmd.rd_power)
        begin
            power_raw_reg  <= power_mem[power_addr];
            power_zero_reg <= (power_addr == '0);
        end
    end

    assign prefix_q = prefix_zero_reg ? '0 : prefix_raw_reg;
    assign power_q  = power_zero_reg ? hash_t'(1) : power_raw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            op_a_reg <= (cmd.opa_sel == OPA_POWER) ? power_q : prefix_q;
            op_b_reg <= (cmd.opb_sel == OPB_POWER) ? power_q
                                                   : {{(HASH_W-BASE_W){1'b0}}, hash_base};
        end
    end

    rph_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_a   (op_a_reg),
        .op_b   (op_b_reg),
        .done   (mul_done),
        .result (mul_result)
    );

    assign add_wide = {1'b0, mul_result} + {{(HASH_W+1-SYM_W){1'b0}}, sym_reg};
    assign sub_wide = {1'b0, prefix_q} + {1'b0, MERSENNE_P} - {1'b0, mul_result};

    always_comb
    begin
        unique case (cmd.hv_sel)
            HV_PREFIX: hv_next = prefix_q;
            HV_ADD:    hv_next = (add_wide >= {1'b0, MERSENNE_P})
                                 ? hash_t'(add_wide - {1'b0, MERSENNE_P})
                                 : add_wide[HASH_W-1:0];
            HV_SUB:    hv_next = (prefix_q >= mul_result) ? (prefix_q - mul_result)
                                                          : sub_wide[HASH_W-1:0];
            default:   hv_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hv_load)
        begin
            hv_reg  <= hv_next;
            err_reg <= cmd.err_val;
        end
        if (cmd.out_load)
        begin
            hv_out_reg  <= hv_reg;
            err_out_reg <= err_reg;
            len_out_reg <= length_count_reg;
        end
    end

    assign stat.action    = act_reg;
    assign stat.full      = (length_count_reg >= LEN_W'(MAX_LEN));
    assign stat.range_err = (end_sum > {1'b0, length_count_reg});
    assign stat.mul_done  = mul_done;

    assign hash_value    = hv_out_reg;
    assign status        = err_out_reg;
    assign stored_length = len_out_reg;

`ifndef SYNTHESIS
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_count_reg <= LEN_W'(MAX_LEN))
        else $error("stored length beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- rtl/rph_ctrl.sv -----
`default_nettype none

// Sequencer: takes one item, steps the datapath through reads, multiplies
// and the final update, then hands the result to the output register.
module rph_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    input  wire rph_pkg::rph_stat_t  stat,
    output rph_pkg::rph_cmd_t        cmd
);
    import rph_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_AP_RD  = 4'd2;
    localparam logic [3:0] ST_AP_M1  = 4'd3;
    localparam logic [3:0] ST_AP_M2  = 4'd4;
    localparam logic [3:0] ST_Q_RD   = 4'd5;
    localparam logic [3:0] ST_Q_M    = 4'd6;
    localparam logic [3:0] ST_PEEK   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.action)
                    ACT_CLEAR:
                    begin
                        cmd.len_clear = 1'b1;
                        cmd.hv_load   = 1'b1;
                        cmd.hv_sel    = HV_ZERO;
                        state_next    = ST_OUT;
                    end
                    ACT_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.hv_load = 1'b1;
                            cmd.hv_sel  = HV_ZERO;
                            cmd.err_val = 1'b1;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            cmd.rd_prefix  = 1'b1;
                            cmd.prefix_sel = PSEL_LEN;
                            cmd.rd_power   = 1'b1;
                            cmd.power_sel  = WSEL_LEN;
                            state_next     = ST_AP_RD;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (stat.range_err)
                        begin
                            cmd.hv_load = 1'b1;
                            cmd.hv_sel  = HV_ZERO;
                            cmd.err_val = 1'b1;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            cmd.rd_prefix  = 1'b1;
                            cmd.prefix_sel = PSEL_POS;
                            cmd.rd_power   = 1'b1;
                            cmd.power_sel  = WSEL_SPAN;
                            state_next     = ST_Q_RD;
                        end
                    end
                    default:
                    begin
                        cmd.rd_prefix  = 1'b1;
                        cmd.prefix_sel = PSEL_LEN;
                        state_next     = ST_PEEK;
                    end
                endcase
            end
            ST_AP_RD:
            begin
                cmd.mul_start = 1'b1;
                cmd.opa_sel   = OPA_PREFIX;
                cmd.opb_sel   = OPB_BASE;
                state_next    = ST_AP_M1;
            end
            ST_AP_M1:
            begin
                if (stat.mul_done)
                begin
                    cmd.hv_load   = 1'b1;
                    cmd.hv_sel    = HV_ADD;
                    cmd.mul_start = 1'b1;
                    cmd.opa_sel   = OPA_POWER;
                    cmd.opb_sel   = OPB_BASE;
                    state_next    = ST_AP_M2;
                end
            end
            ST_AP_M2:
            begin
                if (stat.mul_done)
                begin
                    cmd.append_commit = 1'b1;
                    state_next        = ST_OUT;
                end
            end
            ST_Q_RD:
            begin
                cmd.mul_start  = 1'b1;
                cmd.opa_sel    = OPA_PREFIX;
                cmd.opb_sel    = OPB_POWER;
                cmd.rd_prefix  = 1'b1;
                cmd.prefix_sel = PSEL_END;
                state_next     = ST_Q_M;
            end
            ST_Q_M:
            begin
                if (stat.mul_done)
                begin
                    cmd.hv_load = 1'b1;
                    cmd.hv_sel  = HV_SUB;
                    state_next  = ST_OUT;
                end
            end
            ST_PEEK:
            begin
                cmd.hv_load = 1'b1;
                cmd.hv_sel  = HV_PREFIX;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ----- rtl/rolling_poly_hash_mersenne61.sv -----
// The next item can be accepted in the cycle the result appears on m_tvalid.
// Items are handled one at a time; the rate is set by the single shared 32x32 multiplier
// (four partial products and three reduction steps per modular product) and by m_tready.
// Reset: rst_n is asynchronous and active low; it empties the string, sets hash_base
// to 258 and drops m_tvalid. Memory contents are not cleared and need no sweep.
`default_nettype none

// Prefix polynomial hashes of a byte string modulo 2^61-1.
//
// Each input transaction carries an action in s_tuser. A clear empties the
// string, an append adds one byte and returns the hash of the whole string,
// a query returns the hash of the substring [start_pos, start_pos+span_len),
// and the spare action code returns the whole-string hash without changes.
// Append on a full store and a query reaching past the stored length return
// status 1 with a zero hash. Every input transaction gives exactly one output
// transaction, which also reports the stored length after the item.
//
// The prefix hash and matching base power of every prefix are kept in two
// memories. Entry zero of each is a constant (hash zero, power one) and is
// supplied by a bypass instead of a memory word, so no clearing pass is
// needed. A query costs three memory reads and one modular product; an append
// costs two reads, two modular products and a write to both memories.
//
// The result sits in an output register, so a new item is taken as soon as
// the sequencer is back in its idle state, even if the last result has not
// yet been taken downstream.
//
// hash_base is written through the APB port at byte address 0. It should only
// be changed while the block is idle; bytes already stored keep their old base.
module rolling_poly_hash_mersenne61 (
    input  wire         clk,
    input  wire         rst_n,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // [7:0] symbol, [18:8] start_pos, [29:19] span_len
    input  wire [1:0]   s_tuser,   // [1:0] action
    // Output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // [60:0] hash_value, [71:61] stored_length
    output logic [0:0]  m_tuser    // [0] status
);
    import rph_pkg::*;

    logic [BASE_W-1:0] hash_base_reg;
    rph_cmd_t          cmd;
    rph_stat_t         stat;
    hash_t             hash_value;
    logic              status;
    len_t              stored_length;

    // Configuration register: written on the access phase of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_base_reg <= RESET_BASE;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_HASH_BASE))
        begin
            hash_base_reg <= pwdata[BASE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HASH_BASE) ? {{(32-BASE_W){1'b0}}, hash_base_reg}
                                                : 32'd0;

    rph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rph_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .hash_base     (hash_base_reg),
        .in_action     (s_tuser[ACT_W-1:0]),
        .in_symbol     (s_tdata[7:0]),
        .in_start_pos  (s_tdata[18:8]),
        .in_span_len   (s_tdata[29:19]),
        .hash_value    (hash_value),
        .status        (status),
        .stored_length (stored_length)
    );

    // Output packing: hash in the low bits, length above it, status in tuser.
    assign m_tdata = {stored_length, hash_value};
    assign m_tuser = status;

endmodule

`default_nettype wire
